// ===== rtl/sie_pkg.sv =====
package sie_pkg;

  localparam int MEM_BYTES_DEF = 1048576;
  localparam int WORD_W = 24;
  localparam int START_W = 20;
  localparam int END_W = 21;

  // Item operations.
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_EXEC    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  // Format 2 opcodes (whole first byte).
  localparam logic [7:0] OPC_CLEAR = 8'hB4;
  localparam logic [7:0] OPC_COMPR = 8'hA0;
  localparam logic [7:0] OPC_TIXR  = 8'hB8;

  // Format 3/4 opcodes (first byte with n/i masked off).
  localparam logic [7:0] OPC_J    = 8'h3C;
  localparam logic [7:0] OPC_JEQ  = 8'h30;
  localparam logic [7:0] OPC_JLT  = 8'h38;
  localparam logic [7:0] OPC_JSUB = 8'h48;
  localparam logic [7:0] OPC_RSUB = 8'h4C;
  localparam logic [7:0] OPC_LDA  = 8'h00;
  localparam logic [7:0] OPC_LDB  = 8'h68;
  localparam logic [7:0] OPC_LDT  = 8'h74;
  localparam logic [7:0] OPC_LDCH = 8'h50;
  localparam logic [7:0] OPC_STA  = 8'h0C;
  localparam logic [7:0] OPC_STL  = 8'h14;
  localparam logic [7:0] OPC_STX  = 8'h10;
  localparam logic [7:0] OPC_STCH = 8'h54;
  localparam logic [7:0] OPC_COMP = 8'h28;
  localparam logic [7:0] OPC_RD   = 8'hD8;
  localparam logic [7:0] OPC_TD   = 8'hE0;

  // Addressing modes (n/i bits).
  localparam logic [1:0] NI_SIC  = 2'd0;
  localparam logic [1:0] NI_IMM  = 2'd1;
  localparam logic [1:0] NI_IND  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_MEMRD_W, S_RESP, S_RREQ, S_RWAIT, S_DEC, S_F2, S_F2X, S_F2C,
    S_T0, S_T1, S_T2, S_T3, S_OPND, S_IND, S_VAL, S_EXEC, S_WR
  } state_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

// ===== rtl/sicxe_instruction_executor.sv =====
// Byte memory with a small SIC/XE register machine around it.
// Input channel (in_valid/in_stall) carries op, address and write_byte. A write
// item stores a byte, a read item fetches one, a restart item loads the program
// counter from start_address and an execute item runs one instruction at the
// program counter. Every item gives exactly one result on the output channel
// (out_valid/out_stall): the read byte (zero unless a read) and all registers.
// One item is in flight at a time; in_stall is high from the accepting edge until
// the result is transferred. Write, restart and an execute at or past the end
// go straight to the result, a read first captures the memory byte, and of the
// instructions format 2 is shortest and an indirect format 4 load is longest.
// The time is set by the single-port memory, where each byte is a request and
// then a capture, and by the one shared adder and comparator that forms the
// program counter, the target address, X and SW in turn.
// While out_stall is high the result and all registers hold still.
// Reset clears the registers and configuration; memory contents are not defined
// until written and must be loaded by write items before running.
// Configuration (cfg_write, cfg_index, cfg_data) must be written by the user only while idle; not enforced.
module sicxe_instruction_executor import sie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [END_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [19:0]        address,
  input  logic [7:0]         write_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_byte,
  output logic [WORD_W-1:0]  reg_a,
  output logic [WORD_W-1:0]  reg_x,
  output logic [WORD_W-1:0]  reg_l,
  output logic [WORD_W-1:0]  reg_b,
  output logic [WORD_W-1:0]  reg_s,
  output logic [WORD_W-1:0]  reg_t,
  output logic [WORD_W-1:0]  prog_counter,
  output logic [WORD_W-1:0]  status_word,
  output logic               done_res
);

  localparam int AW = $clog2(MEM_BYTES);

  state_t state, state_next, ret;
  logic [START_W-1:0] start_addr;
  logic [END_W-1:0]   end_addr;
  logic [WORD_W-1:0]  ra, rx, rl, rb, rs, rt, pc, sw;
  logic [WORD_W-1:0]  ir, word, tgt, ea, maddr;
  logic [1:0]         cnt;
  logic               fmt4;
  logic [7:0]         rbyte;

  mem_ctl_t           mctl;
  logic [AW-1:0]      maddr_mux;
  logic [7:0]         mwdata, mrdata;
  logic [WORD_W-1:0]  alu_a, alu_b, alu_sum, alu_cmp;

  logic accept, running;
  logic [7:0] b0, b1, opc, w0;
  logic [1:0] ni, wni;
  logic [WORD_W-1:0] disp;
  logic is_store, uses_ea, is_word_ld;

  function automatic logic [WORD_W-1:0] reg_get(input logic [3:0] n,
      input logic [WORD_W-1:0] a, x, l, b, s, t, p, w);
    logic [WORD_W-1:0] v;
    v = '0;
    case (n)
      4'd0: v = a;
      4'd1: v = x;
      4'd2: v = l;
      4'd3: v = b;
      4'd4: v = s;
      4'd5: v = t;
      4'd8: v = p;
      4'd9: v = w;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign accept  = in_valid && !in_stall;
  assign running = pc < {{(WORD_W-END_W){1'b0}}, end_addr};

  assign b0  = ir[23:16];
  assign b1  = ir[15:8];
  assign ni  = b0[1:0];
  assign opc = {b0[7:2], 2'b00};
  assign w0   = word[23:16];
  assign wni  = w0[1:0];

  always_comb begin
    is_store = 1'b0;
    uses_ea = 1'b0;
    is_word_ld = 1'b0;
    case (opc)
      OPC_STA, OPC_STL, OPC_STX, OPC_STCH: is_store = 1'b1;
      OPC_J, OPC_JEQ, OPC_JLT, OPC_JSUB, OPC_LDCH: uses_ea = 1'b1;
      OPC_LDA, OPC_LDB, OPC_LDT, OPC_COMP: begin
        uses_ea = 1'b1;
        is_word_ld = 1'b1;
      end
      default: ;
    endcase
  end

  // Displacement before any register is added in.
  always_comb begin
    if (ni == NI_SIC) begin
      disp = {9'b0, b1[6:0], ir[7:0]};
    end else if (fmt4) begin
      disp = {4'b0, b1[3:0], ir[7:0], word[7:0]};
    end else if (b1[5]) begin
      disp = {{12{b1[3]}}, b1[3:0], ir[7:0]};
    end else begin
      disp = {12'b0, b1[3:0], ir[7:0]};
    end
  end

  sie_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .cmp (alu_cmp)
  );

  sie_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk   (clk),
    .ctl   (mctl),
    .addr  (maddr_mux),
    .wdata (mwdata),
    .rdata (mrdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mctl = '{en: 1'b0, we: 1'b0};
    maddr_mux = maddr[AW-1:0];
    mwdata = word[23:16];
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_IDLE: begin
        maddr_mux = address[AW-1:0];
        mwdata = write_byte;
        if (accept) begin
          case (op)
            OP_WRITE: begin
              mctl = '{en: 1'b1, we: 1'b1};
              state_next = S_RESP;
            end
            OP_READ: begin
              mctl = '{en: 1'b1, we: 1'b0};
              state_next = S_MEMRD_W;
            end
            OP_RESTART: state_next = S_RESP;
            default: state_next = running ? S_RREQ : S_RESP;
          endcase
        end
      end
      S_MEMRD_W: state_next = S_RESP;
      S_RESP: if (!out_stall) state_next = S_IDLE;
      S_RREQ: begin
        mctl = '{en: 1'b1, we: 1'b0};
        state_next = S_RWAIT;
      end
      S_RWAIT: state_next = (cnt == 2'd1) ? ret : S_RREQ;
      S_DEC: begin
        if (w0 == OPC_CLEAR || w0 == OPC_COMPR || w0 == OPC_TIXR) begin
          state_next = S_F2;
        end else if (wni != NI_SIC && word[12]) begin
          state_next = S_RREQ;
        end else begin
          state_next = S_T0;
        end
      end
      S_F2: begin
        alu_a = pc;
        alu_b = WORD_W'(2);
        state_next = S_F2X;
      end
      S_F2X: begin
        if (b0 == OPC_TIXR) begin
          alu_a = rx;
          alu_b = WORD_W'(1);
          state_next = S_F2C;
        end else begin
          alu_a = reg_get(b1[7:4], ra, rx, rl, rb, rs, rt, pc, sw);
          alu_b = reg_get(b1[3:0], ra, rx, rl, rb, rs, rt, pc, sw);
          state_next = S_RESP;
        end
      end
      S_F2C: begin
        alu_a = rx;
        alu_b = reg_get(b1[7:4], ra, rx, rl, rb, rs, rt, pc, sw);
        state_next = S_RESP;
      end
      S_T0: begin
        alu_a = pc;
        alu_b = fmt4 ? WORD_W'(4) : WORD_W'(3);
        state_next = S_T1;
      end
      S_T1: begin
        alu_a = tgt;
        alu_b = (ni != NI_SIC && !fmt4 && b1[5]) ? pc : '0;
        state_next = S_T2;
      end
      S_T2: begin
        alu_a = tgt;
        alu_b = (ni != NI_SIC && b1[6]) ? rb : '0;
        state_next = S_T3;
      end
      S_T3: begin
        alu_a = tgt;
        alu_b = b1[7] ? rx : '0;
        state_next = S_OPND;
      end
      S_OPND: begin
        if (is_store) begin
          state_next = S_WR;
        end else if (ni == NI_IND && uses_ea) begin
          state_next = S_RREQ;
        end else begin
          state_next = S_VAL;
        end
      end
      S_IND: state_next = S_VAL;
      S_VAL: begin
        if (ni != NI_IMM && (is_word_ld || opc == OPC_LDCH)) begin
          state_next = S_RREQ;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        alu_a = ra;
        alu_b = word;
        state_next = S_RESP;
      end
      S_WR: begin
        mctl = '{en: 1'b1, we: 1'b1};
        if (cnt == 2'd1) state_next = S_RESP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= '0;
      end_addr <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_START) begin
        start_addr <= cfg_data[START_W-1:0];
      end else begin
        end_addr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ra <= '0;
      rx <= '0;
      rl <= '0;
      rb <= '0;
      rs <= '0;
      rt <= '0;
      pc <= '0;
      sw <= '0;
    end else begin
      case (state)
        S_IDLE: if (accept && op == OP_RESTART) pc <= WORD_W'(start_addr);
        S_F2: pc <= alu_sum;
        S_F2X: begin
          if (b0 == OPC_TIXR) begin
            rx <= alu_sum;
          end else if (b0 == OPC_COMPR) begin
            sw <= alu_cmp;
          end else begin
            case (b1[7:4])
              4'd0: ra <= '0;
              4'd1: rx <= '0;
              4'd2: rl <= '0;
              4'd3: rb <= '0;
              4'd4: rs <= '0;
              4'd5: rt <= '0;
              4'd8: pc <= '0;
              4'd9: sw <= '0;
              default: ;
            endcase
          end
        end
        S_F2C: sw <= alu_cmp;
        S_T0: pc <= alu_sum;
        S_EXEC: begin
          case (opc)
            OPC_J: pc <= ea;
            OPC_JEQ: if (sw == '0) pc <= ea;
            OPC_JLT: if (sw[WORD_W-1]) pc <= ea;
            OPC_JSUB: begin
              rl <= pc;
              pc <= ea;
            end
            OPC_RSUB: pc <= rl;
            OPC_LDA: ra <= word;
            OPC_LDB: rb <= word;
            OPC_LDT: rt <= word;
            OPC_COMP: sw <= alu_cmp;
            OPC_LDCH: ra[7:0] <= word[7:0];
            OPC_RD: ra[7:0] <= 8'h00;
            OPC_TD: sw <= '1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, with the byte count and return state; these are not reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          rbyte <= 8'h00;
          maddr <= pc;
          cnt <= 2'd3;
          ret <= S_DEC;
        end
      end
      S_MEMRD_W: rbyte <= mrdata;
      S_RWAIT: begin
        word <= {word[15:0], mrdata};
        maddr <= maddr + WORD_W'(1);
        cnt <= cnt - 2'd1;
      end
      S_DEC: begin
        ir <= word;
        fmt4 <= wni != NI_SIC && word[12];
        maddr <= pc + WORD_W'(3);
        cnt <= 2'd1;
        ret <= S_T0;
      end
      S_T0: tgt <= disp;
      S_T1, S_T2, S_T3: tgt <= alu_sum;
      S_OPND: begin
        maddr <= tgt;
        ea <= tgt;
        cnt <= (opc == OPC_STCH) ? 2'd1 : 2'd3;
        ret <= S_IND;
        case (opc)
          OPC_STA: word <= ra;
          OPC_STL: word <= rl;
          OPC_STX: word <= rx;
          OPC_STCH: word <= {ra[7:0], 16'h0000};
          default: ;
        endcase
      end
      S_IND: ea <= word;
      S_VAL: begin
        maddr <= ea;
        cnt <= (opc == OPC_LDCH) ? 2'd1 : 2'd3;
        ret <= S_EXEC;
        if (ni == NI_IMM) word <= tgt;
      end
      S_WR: begin
        word <= {word[15:0], 8'h00};
        maddr <= maddr + WORD_W'(1);
        cnt <= cnt - 2'd1;
      end
      default: ;
    endcase
  end

  assign in_stall     = state != S_IDLE;
  assign out_valid    = state == S_RESP;
  assign read_byte    = rbyte;
  assign reg_a        = ra;
  assign reg_x        = rx;
  assign reg_l        = rl;
  assign reg_b        = rb;
  assign reg_s        = rs;
  assign reg_t        = rt;
  assign prog_counter = pc;
  assign status_word  = sw;
  assign done_res     = !running;

endmodule

// ===== rtl/sie_mem.sv =====
module sie_mem import sie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  localparam int AW = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/sie_alu.sv =====
module sie_alu import sie_pkg::*; (
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] sum,
  output logic [WORD_W-1:0] cmp
);

  always_comb begin
    sum = a + b;
    if (a == b) begin
      cmp = '0;
    end else if ($signed(a) > $signed(b)) begin
      cmp = WORD_W'(1);
    end else begin
      cmp = '1;
    end
  end

endmodule

// ===== rtl/sie_checker.sv =====
module sie_checker import sie_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] prog_counter,
  input logic [WORD_W-1:0] reg_a
);

  // Only one item is in flight, so no input transfer while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input transfer while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid) || out_valid)
    else $error("block idle right after an input transfer");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated after its transfer");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(prog_counter) && $stable(reg_a))
    else $error("stalled result changed");

endmodule

bind sicxe_instruction_executor sie_checker u_sie_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .prog_counter (prog_counter),
  .reg_a        (reg_a)
);
